### hdl/mbms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the masked bilinear map sampler.
// No dependencies; every other file of the block but mbms_ram imports this package.
package mbms_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_DATA_W-1:0] MAP_SIZE_RESET = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_NORMALS    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    ALU_LERP   = 1'b0,
    ALU_SQUARE = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LERP,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_LEFT,
    PH_RIGHT,
    PH_FINAL
  } phase_e;

  typedef struct packed {
    logic               operation;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    logic signed [31:0] cell_pos_x;
    logic signed [31:0] cell_pos_y;
    logic signed [31:0] cell_pos_z;
    logic               cell_valid;
    logic signed [15:0] cell_nrm_x;
    logic signed [15:0] cell_nrm_y;
    logic signed [15:0] cell_nrm_z;
    logic [16:0]        coord_u;
    logic [16:0]        coord_v;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_nrm_x;
    logic signed [15:0] out_nrm_y;
    logic signed [15:0] out_nrm_z;
  } result_t;

  // One map cell or partial sample: element 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic             ok;
    logic [2:0][31:0] p;
    logic [2:0][15:0] n;
  } cell_t;

endpackage
`default_nettype wire

### hdl/mbms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/mbms_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared multiply unit: rounded lerp a + floor(((b-a)*t + 0x8000) / 2^16), or a square.
// Depends on mbms_pkg.
module mbms_alu (
  input  mbms_pkg::alu_op_e  op,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  input  logic [15:0]        t,
  output logic signed [32:0] y
);
  import mbms_pkg::*;

  logic signed [33:0] mx;
  logic signed [16:0] my;
  logic signed [50:0] prod;
  logic signed [50:0] rnd;

  always_comb begin
    if (op == ALU_SQUARE) begin
      mx = 34'(a);
      my = $signed(a[16:0]);
    end else begin
      mx = 34'(b) - 34'(a);
      my = $signed({1'b0, t});
    end
    prod = mx * my;
    rnd  = prod + 51'sd32768;
    if (op == ALU_SQUARE) begin
      y = 33'(prod);
    end else begin
      y = 33'(34'(a) + 34'(rnd >>> 16));
    end
  end

endmodule
`default_nettype wire

### hdl/masked_bilinear_map_sampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Masked bilinear map sampler. A write item stores one cell in the cycle of its transfer.
// A sample item passes through its transfer cycle, four cell reads through the one map
// read port, the steps of the single shared lerp unit (left side, right side, final mix,
// six components each) and a load of the result register. With normals on, a hit adds
// three squaring steps, a bit-serial square root and, unless the root is zero, three
// bit-serial divides (each a load and then the divide steps) on one shared subtractor.
// While the previous result is stalled, the sample waits to load its result. No new item
// is taken while a sample is in work. The map stores have no reset; sample only cells that
// have been written.
module masked_bilinear_map_sampler_top #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  mbms_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mbms_pkg::result_t                  result,
  input  logic                               cfg_write,
  input  logic [mbms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbms_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mbms_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int XF_W  = 17 + CW;
  localparam int YF_W  = 17 + RW;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] cell_addr(input logic [31:0] col, input logic [31:0] row);
    cell_addr = AW'(row * 32'(MAX_COLS) + col);
  endfunction

  // configuration
  logic [CFG_DATA_W-1:0] map_width;
  logic [CFG_DATA_W-1:0] map_height;
  logic                  normals_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width       <= MAP_SIZE_RESET;
      map_height      <= MAP_SIZE_RESET;
      normals_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_MAP_WIDTH:  map_width       <= cfg_data;
        CFG_MAP_HEIGHT: map_height      <= cfg_data;
        CFG_NORMALS:    normals_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_e state, state_next;
  phase_e phase;
  logic [5:0] cnt;
  logic [2:0] k;

  logic item_accept;
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  // sample setup: clamp, scale, split into cell index and fraction
  logic [31:0]     w_eff, h_eff;
  logic [CW-1:0]   wm1;
  logic [RW-1:0]   hm1;
  logic [16:0]     u_c, v_c;
  logic [XF_W-1:0] xf;
  logic [YF_W-1:0] yf;

  always_comb begin
    w_eff = 32'(map_width);
    if (w_eff < 32'd2) w_eff = 32'd2;
    if (w_eff > 32'(MAX_COLS)) w_eff = 32'(MAX_COLS);
    h_eff = 32'(map_height);
    if (h_eff < 32'd2) h_eff = 32'd2;
    if (h_eff > 32'(MAX_ROWS)) h_eff = 32'(MAX_ROWS);
    wm1 = CW'(w_eff - 32'd1);
    hm1 = RW'(h_eff - 32'd1);
    u_c = (item.coord_u > 17'd65536) ? 17'd65536 : item.coord_u;
    v_c = (item.coord_v > 17'd65536) ? 17'd65536 : item.coord_v;
    xf  = XF_W'(u_c) * XF_W'(wm1);
    yf  = YF_W'(v_c) * YF_W'(hm1);
  end

  logic [CW-1:0] x0, x1;
  logic [RW-1:0] y0, y1;
  logic [15:0]   fx, fy;

  // map stores
  logic          map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [96:0]   pos_rd;
  logic [47:0]   nrm_rd;

  assign map_we = item_accept && (op_e'(item.operation) == OP_WRITE)
                  && (32'(item.cell_col) < 32'(MAX_COLS))
                  && (32'(item.cell_row) < 32'(MAX_ROWS));
  assign map_waddr = cell_addr(32'(item.cell_col), 32'(item.cell_row));

  always_comb begin
    case (cnt[1:0])
      2'd0:    map_raddr = cell_addr(32'(x0), 32'(y0));
      2'd1:    map_raddr = cell_addr(32'(x0), 32'(y1));
      2'd2:    map_raddr = cell_addr(32'(x1), 32'(y0));
      default: map_raddr = cell_addr(32'(x1), 32'(y1));
    endcase
  end

  mbms_ram #(.WIDTH(97), .DEPTH(DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata ({item.cell_valid, item.cell_pos_z, item.cell_pos_y, item.cell_pos_x}),
    .raddr (map_raddr),
    .rdata (pos_rd)
  );

  mbms_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_nrm_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata ({item.cell_nrm_z, item.cell_nrm_y, item.cell_nrm_x}),
    .raddr (map_raddr),
    .rdata (nrm_rd)
  );

  // corners and partial results
  cell_t ll, ul, lr, ur, lft, rgt, res;

  // shared lerp / square unit
  cell_t              src_a, src_b;
  logic [15:0]        frac;
  logic [1:0]         ci;
  alu_op_e            alu_op;
  logic signed [32:0] alu_a, alu_b, alu_y;
  logic signed [32:0] comb_val;
  logic               both_ok, keep_a, keep_b, ok_c;

  always_comb begin
    case (phase)
      PH_LEFT:  begin src_a = ll;  src_b = ul;  frac = fy; end
      PH_RIGHT: begin src_a = lr;  src_b = ur;  frac = fy; end
      default:  begin src_a = lft; src_b = rgt; frac = fx; end
    endcase
    ci = (k < 3'd3) ? k[1:0] : 2'(k - 3'd3);
    if (state == ST_SQUARE) begin
      alu_op = ALU_SQUARE;
      alu_a  = 33'($signed(res.n[k[1:0]]));
      alu_b  = '0;
    end else begin
      alu_op = ALU_LERP;
      if (k < 3'd3) begin
        alu_a = 33'($signed(src_a.p[ci]));
        alu_b = 33'($signed(src_b.p[ci]));
      end else begin
        alu_a = 33'($signed(src_a.n[ci]));
        alu_b = 33'($signed(src_b.n[ci]));
      end
    end
    // one valid corner survives only on its own half
    both_ok = src_a.ok && src_b.ok;
    keep_a  = src_a.ok && !src_b.ok && !frac[15];
    keep_b  = !src_a.ok && src_b.ok && frac[15];
    ok_c    = both_ok || keep_a || keep_b;
    if (both_ok)     comb_val = alu_y;
    else if (keep_a) comb_val = alu_a;
    else if (keep_b) comb_val = alu_b;
    else             comb_val = '0;
  end

  mbms_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .t  (frac),
    .y  (alu_y)
  );

  // shared compare/subtract for the square root and the divides
  logic [31:0] l2;
  logic [47:0] sh;
  logic [25:0] rem;
  logic [23:0] root;
  logic [37:0] quo;
  logic [25:0] sub_a, sub_b;
  logic [26:0] sub_d;
  logic        sub_ge;

  always_comb begin
    if (state == ST_SQRT) begin
      sub_a = {rem[23:0], sh[47:46]};
      sub_b = {root, 2'b01};
    end else begin
      sub_a = {rem[24:0], sh[47]};
      sub_b = {2'b00, root};
    end
    sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge = !sub_d[26];
  end

  logic signed [15:0] nval;
  logic [15:0]        mag;
  logic [37:0]        quo_fin;
  logic [2:0][15:0]   nrm_out;

  always_comb begin
    mag     = res.n[k[1:0]][15] ? 16'(16'd0 - res.n[k[1:0]]) : res.n[k[1:0]];
    quo_fin = {quo[36:0], sub_ge};
    if (res.n[k[1:0]][15]) begin
      nval = (quo_fin > 38'd32768) ? 16'sh8000 : $signed(16'(16'd0 - quo_fin[15:0]));
    end else begin
      nval = (quo_fin > 38'd32767) ? 16'sh7fff : $signed(quo_fin[15:0]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_accept && op_e'(item.operation) == OP_SAMPLE) state_next = ST_READ;
      end
      ST_READ: begin
        if (cnt == 6'd4) state_next = ST_LERP;
      end
      ST_LERP: begin
        if (k == 3'd5 && phase == PH_FINAL) begin
          state_next = (ok_c && normals_enabled) ? ST_SQUARE : ST_DONE;
        end
      end
      ST_SQUARE: begin
        if (k == 3'd2) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == 6'd23) state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        state_next = (root == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == 6'd37) state_next = (k == 3'd2) ? ST_DONE : ST_DIV_LOAD;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      k     <= '0;
      phase <= PH_LEFT;
    end else begin
      cnt <= (state_next != state) ? 6'd0 : cnt + 6'd1;
      unique case (state)
        ST_IDLE: begin
          k     <= '0;
          phase <= PH_LEFT;
        end
        ST_LERP: begin
          if (k == 3'd5) begin
            k <= '0;
            unique case (phase)
              PH_LEFT:  phase <= PH_RIGHT;
              PH_RIGHT: phase <= PH_FINAL;
              default:  phase <= PH_LEFT;
            endcase
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_SQUARE: k <= (k == 3'd2) ? 3'd0 : k + 3'd1;
        ST_DIV: begin
          if (cnt == 6'd37) k <= k + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_accept) begin
          x0      <= xf[16 +: CW];
          x1      <= xf[16 +: CW] + CW'(xf[15:0] != 16'd0);
          fx      <= xf[15:0];
          y0      <= yf[16 +: RW];
          y1      <= yf[16 +: RW] + RW'(yf[15:0] != 16'd0);
          fy      <= yf[15:0];
          nrm_out <= '0;
        end
      end
      ST_READ: begin
        case (cnt[2:0])
          3'd1:    ll <= '{ok: pos_rd[96], p: pos_rd[95:0], n: nrm_rd};
          3'd2:    ul <= '{ok: pos_rd[96], p: pos_rd[95:0], n: nrm_rd};
          3'd3:    lr <= '{ok: pos_rd[96], p: pos_rd[95:0], n: nrm_rd};
          3'd4:    ur <= '{ok: pos_rd[96], p: pos_rd[95:0], n: nrm_rd};
          default: ;
        endcase
      end
      ST_LERP: begin
        case (phase)
          PH_LEFT: begin
            lft.ok <= ok_c;
            if (k < 3'd3) lft.p[ci] <= comb_val[31:0];
            else          lft.n[ci] <= comb_val[15:0];
          end
          PH_RIGHT: begin
            rgt.ok <= ok_c;
            if (k < 3'd3) rgt.p[ci] <= comb_val[31:0];
            else          rgt.n[ci] <= comb_val[15:0];
          end
          default: begin
            res.ok <= ok_c;
            if (k < 3'd3) res.p[ci] <= comb_val[31:0];
            else          res.n[ci] <= comb_val[15:0];
          end
        endcase
      end
      ST_SQUARE: begin
        if (k == 3'd0) begin
          l2 <= alu_y[31:0];
        end else begin
          l2 <= l2 + alu_y[31:0];
        end
        if (k == 3'd2) begin
          sh   <= {l2 + alu_y[31:0], 16'd0};
          rem  <= '0;
          root <= '0;
        end
      end
      ST_SQRT: begin
        sh   <= {sh[45:0], 2'b00};
        rem  <= sub_ge ? sub_d[25:0] : sub_a;
        root <= {root[22:0], sub_ge};
      end
      ST_DIV_LOAD: begin
        sh  <= {38'({mag, 22'd0}) + 38'(root >> 1), 10'd0};
        rem <= '0;
        quo <= '0;
      end
      ST_DIV: begin
        sh  <= {sh[46:0], 1'b0};
        rem <= sub_ge ? sub_d[25:0] : sub_a;
        quo <= quo_fin;
        if (cnt == 6'd37) nrm_out[k[1:0]] <= nval;
      end
      default: ;
    endcase
  end

  // output register
  logic result_load;
  assign result_load = (state == ST_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (result_valid && result_stall) || result_load;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.hit       <= res.ok;
      result.out_pos_x <= $signed(res.p[0]);
      result.out_pos_y <= $signed(res.p[1]);
      result.out_pos_z <= $signed(res.p[2]);
      result.out_nrm_x <= $signed(nrm_out[0]);
      result.out_nrm_y <= $signed(nrm_out[1]);
      result.out_nrm_z <= $signed(nrm_out[2]);
    end
  end

endmodule
`default_nettype wire

### hdl/mbms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the masked bilinear map sampler, bound to its top level.
// Depends on mbms_pkg and masked_bilinear_map_sampler_top.
module mbms_assertions (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_stall,
  input mbms_pkg::item_t                    item,
  input logic                               result_valid,
  input logic                               result_stall,
  input mbms_pkg::result_t                  result
);
  import mbms_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a cell write finishes in the cycle of its transfer
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_WRITE |=> !item_stall)
    else $error("write transfer blocked the input");

  // a sample keeps the input closed while it is worked on
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_SAMPLE |=> item_stall)
    else $error("input open right after a sample transfer");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |->
      result.out_pos_x == 0 && result.out_pos_y == 0 && result.out_pos_z == 0 &&
      result.out_nrm_x == 0 && result.out_nrm_y == 0 && result.out_nrm_z == 0)
    else $error("miss with nonzero fields");

endmodule

bind masked_bilinear_map_sampler_top mbms_assertions u_mbms_assertions (.*);
`default_nettype wire

### test/mbms_checker.sv
`timescale 1ns / 1ps
// Checker for the masked bilinear map sampler: watches the item, result and register ports,
// keeps its own copy of the map and registers, and compares each result with its prediction.
// Depends on mbms_pkg for the payload types and register codes.
module mbms_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  mbms_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  mbms_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  output int                errors,
  output int                pending,
  output int                hits
);
  import mbms_pkg::*;

  localparam int COLS  = 256;
  localparam int CELLS = 65536;

  typedef struct {
    bit     ok;
    longint p[3];
    longint n[3];
  } blend_t;

  logic signed [31:0] map_pos [CELLS][3];
  logic signed [15:0] map_nrm [CELLS][3];
  bit                 map_ok  [CELLS];

  logic [8:0] width_reg, height_reg;
  logic       nrm_on;
  result_t    expected_samples[$];

  function automatic blend_t fetch(int unsigned col, int unsigned row);
    blend_t      c;
    int unsigned a;
    a = (row * COLS + col) % CELLS;
    c.ok = map_ok[a];
    for (int k = 0; k < 3; k++) begin
      c.p[k] = map_pos[a][k];
      c.n[k] = map_nrm[a][k];
    end
    return c;
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + (((b - a) * t + 64'sh8000) >>> 16);
  endfunction

  // Keep a lone valid corner only on its own half; otherwise leave the side empty.
  function automatic blend_t mix(blend_t a, blend_t b, longint t);
    blend_t r;
    r.ok = 0;
    for (int k = 0; k < 3; k++) begin
      r.p[k] = 0;
      r.n[k] = 0;
    end
    if (a.ok && b.ok) begin
      r.ok = 1;
      for (int k = 0; k < 3; k++) begin
        r.p[k] = lerp(a.p[k], b.p[k], t);
        r.n[k] = lerp(a.n[k], b.n[k], t);
      end
    end else if (a.ok) begin
      if (t < 'h8000) r = a;
    end else if (b.ok) begin
      if (t >= 'h8000) r = b;
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic result_t sample_map(item_t it);
    result_t         res;
    int unsigned     w, h, u, v, xf, yf, x0, y0, x1, y1, fx, fy;
    blend_t          lft, rgt, fin;
    longint unsigned l2, len, mag, q;
    longint          s;
    w = width_reg;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > COLS) w = COLS;
    if (h < 2) h = 2;
    if (h > 256) h = 256;
    u = it.coord_u > 65536 ? 65536 : it.coord_u;
    v = it.coord_v > 65536 ? 65536 : it.coord_v;
    xf = u * (w - 1);
    yf = v * (h - 1);
    x0 = xf >> 16;
    fx = xf & 'hFFFF;
    y0 = yf >> 16;
    fy = yf & 'hFFFF;
    x1 = x0 + (fx != 0);
    y1 = y0 + (fy != 0);
    lft = mix(fetch(x0, y0), fetch(x0, y1), fy);
    rgt = mix(fetch(x1, y0), fetch(x1, y1), fy);
    fin = mix(lft, rgt, fx);
    res = '0;
    if (fin.ok) begin
      res.hit       = 1'b1;
      res.out_pos_x = fin.p[0][31:0];
      res.out_pos_y = fin.p[1][31:0];
      res.out_pos_z = fin.p[2][31:0];
      if (nrm_on) begin
        l2 = 0;
        for (int k = 0; k < 3; k++) l2 += longint'(fin.n[k] * fin.n[k]);
        len = int_sqrt(l2 << 16);
        if (len != 0) begin
          for (int k = 0; k < 3; k++) begin
            mag = fin.n[k] < 0 ? -fin.n[k] : fin.n[k];
            q = ((mag << 22) + (len >> 1)) / len;
            s = q > 65536 ? 65536 : longint'(q);
            if (fin.n[k] < 0) s = -s;
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            case (k)
              0: res.out_nrm_x = s[15:0];
              1: res.out_nrm_y = s[15:0];
              default: res.out_nrm_z = s[15:0];
            endcase
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void field_check(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t     e;
    int unsigned a;
    if (rst) begin
      width_reg  <= MAP_SIZE_RESET;
      height_reg <= MAP_SIZE_RESET;
      nrm_on     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAP_WIDTH:  width_reg  <= cfg_data;
          CFG_MAP_HEIGHT: height_reg <= cfg_data;
          CFG_NORMALS:    nrm_on     <= cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        if (item.operation == OP_WRITE) begin
          a = item.cell_row * COLS + item.cell_col;
          map_pos[a][0] = item.cell_pos_x;
          map_pos[a][1] = item.cell_pos_y;
          map_pos[a][2] = item.cell_pos_z;
          map_nrm[a][0] = item.cell_nrm_x;
          map_nrm[a][1] = item.cell_nrm_y;
          map_nrm[a][2] = item.cell_nrm_z;
          map_ok[a]     = item.cell_valid;
        end else begin
          expected_samples.push_back(sample_map(item));
        end
      end
      if (result_valid && !result_stall) begin
        if (expected_samples.size() == 0) begin
          $error("result transfer with no lookup outstanding");
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (e.hit) hits++;
          field_check("hit", e.hit, result.hit);
          field_check("out_pos_x", e.out_pos_x, result.out_pos_x);
          field_check("out_pos_y", e.out_pos_y, result.out_pos_y);
          field_check("out_pos_z", e.out_pos_z, result.out_pos_z);
          field_check("out_nrm_x", e.out_nrm_x, result.out_nrm_x);
          field_check("out_nrm_y", e.out_nrm_y, result.out_nrm_y);
          field_check("out_nrm_z", e.out_nrm_z, result.out_nrm_z);
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Top of the masked bilinear map sampler testbench: clock, reset, register setup, cell and
// lookup stimulus, receiver stalls and the verdict. Depends on mbms_pkg, the sampler and mbms_checker.
module tb_top;
  import mbms_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         SETTLE     = 250;
  localparam longint     CYCLE_CAP  = 3000000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending, hits;
  bit written[65536];
  int unsigned map_w = 256, map_h = 256;
  int items_sent = 0, lookups_sent = 0, settings_run = 0;
  int burst_left = 0;
  bit no_gaps = 0;
  int hold_req = 0;
  longint cycles = 0;

  masked_bilinear_map_sampler_top dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  mbms_checker u_checker (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending, .hits
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: switch stall pattern after each random span; honor a long hold-off request.
  initial begin
    int mode, span, served;
    mode = 0;
    span = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_req != served) begin
        served = hold_req;
        result_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(50, 400);
        end
        span--;
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 9) < 3);
          2: result_stall <= ($urandom_range(0, 9) < 8);
          default: result_stall <= (cycles % 7) < 3;
        endcase
      end
    end
  end

  task automatic send(item_t it);
    int g;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (g > 0) begin
        item_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    item       <= it;
    item_valid <= 1'b1;
    do @(negedge clk); while (item_stall);
    @(posedge clk);
    items_sent++;
    if (it.operation == OP_SAMPLE) lookups_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic item_t noise_item();
    item_t        it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  task automatic write_cell(int unsigned col, int unsigned row, int ok,
                            int px, int py, int pz, int nx, int ny, int nz);
    item_t it;
    it = noise_item();
    it.operation  = OP_WRITE;
    it.cell_col   = col[7:0];
    it.cell_row   = row[7:0];
    it.cell_valid = (ok != 0);
    it.cell_pos_x = px;
    it.cell_pos_y = py;
    it.cell_pos_z = pz;
    it.cell_nrm_x = nx[15:0];
    it.cell_nrm_y = ny[15:0];
    it.cell_nrm_z = nz[15:0];
    written[row * 256 + col] = 1;
    send(it);
  endtask

  task automatic write_random(int unsigned col, int unsigned row);
    item_t it;
    it = noise_item();
    // Small normals sometimes, so that near-zero lengths come up.
    if ($urandom_range(0, 3) == 0) begin
      it.cell_nrm_x = 16'($signed(4'($urandom)));
      it.cell_nrm_y = 16'($signed(4'($urandom)));
      it.cell_nrm_z = 16'($signed(4'($urandom)));
    end
    write_cell(col, row, int'($urandom_range(0, 4) != 0), it.cell_pos_x, it.cell_pos_y,
               it.cell_pos_z, int'(it.cell_nrm_x), int'(it.cell_nrm_y),
               int'(it.cell_nrm_z));
  endtask

  // Fill any corner that the lookup would touch and that holds nothing yet, then look up.
  task automatic lookup(int unsigned u, int unsigned v);
    item_t       it;
    int unsigned w, h, uc, vc, xf, yf, xs[2], ys[2];
    w = map_w < 2 ? 2 : (map_w > 256 ? 256 : map_w);
    h = map_h < 2 ? 2 : (map_h > 256 ? 256 : map_h);
    uc = u > 65536 ? 65536 : u;
    vc = v > 65536 ? 65536 : v;
    xf = uc * (w - 1);
    yf = vc * (h - 1);
    xs[0] = xf >> 16;
    xs[1] = xs[0] + ((xf & 'hFFFF) != 0);
    ys[0] = yf >> 16;
    ys[1] = ys[0] + ((yf & 'hFFFF) != 0);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (!written[ys[j] * 256 + xs[i]]) write_random(xs[i], ys[j]);
    it = noise_item();
    it.operation = OP_SAMPLE;
    it.coord_u   = u[16:0];
    it.coord_v   = v[16:0];
    send(it);
  endtask

  task automatic set_map(int unsigned w, int unsigned h, bit nrm, bit stray);
    map_w = w;
    map_h = h;
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data  <= w[8:0];
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data  <= h[8:0];
    @(posedge clk);
    cfg_index <= CFG_NORMALS;
    cfg_data  <= {8'($urandom), nrm};
    @(posedge clk);
    if (stray) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= 9'($urandom);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  function automatic int unsigned rand_coord();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      3: return 'h8000;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  initial begin
    int unsigned ws[6] = '{256, 0, 511, 5, 256, 3};
    int unsigned hs[6] = '{256, 511, 3, 7, 1, 2};
    bit          ns[6] = '{1, 1, 0, 1, 0, 1};
    int          target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x2 map, normals on, extreme contents and the half-point edges.
    set_map(2, 2, 1, 1);
    write_cell(0, 0, 1, 32'sh80000000, 32'sh7FFFFFFF, 0, -32768, 32767, 0);
    write_cell(1, 0, 1, 32'sh7FFFFFFF, 32'sh80000000, -1, 32767, -32768, 1);
    write_cell(0, 1, 0, 0, 0, 0, 0, 0, 0);
    write_cell(1, 1, 1, 12345, -6789, 32'sh10000, 0, 0, 0);
    lookup(0, 0);
    lookup(65536, 65536);
    lookup('h1FFFF, 'h1FFFF);
    lookup('h8000, 'h8000);
    lookup('h7FFF, 'h8000);
    lookup('h8000, 'h7FFF);
    lookup(0, 'hFFFF);
    lookup(0, 65536);
    lookup('h4000, 'hC000);
    write_cell(0, 0, 0, 0, 0, 0, 0, 0, 0);
    write_cell(1, 0, 0, 0, 0, 0, 0, 0, 0);
    write_cell(1, 1, 0, 0, 0, 0, 0, 0, 0);
    lookup('h8000, 'h8000);
    write_cell(1, 1, 1, -1, 1, -1, 0, 0, 0);
    lookup(65536, 65536);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_map(ws[p], hs[p], ns[p], p == 3);
      target = items_sent + 140;
      while (items_sent < target) begin
        if (p == 2 && items_sent == target - 70) begin
          // Hold the receiver off while items keep coming, then pause until all is back.
          hold_req++;
          no_gaps = 1;
          repeat (20) lookup(rand_coord(), rand_coord());
          no_gaps = 0;
          drain();
        end
        case ($urandom_range(0, 9))
          0: write_random($urandom_range(0, 255), $urandom_range(0, 255));
          1: write_random($urandom_range(0, 7), $urandom_range(0, 7));
          default: lookup(rand_coord(), rand_coord());
        endcase
      end
      drain();
    end

    $display("Run covered %0d items, %0d of them lookups (%0d hits), over %0d map settings.",
             items_sent, lookups_sent, hits, settings_run);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/mbms_pkg.sv
hdl/mbms_ram.sv
hdl/mbms_alu.sv
hdl/masked_bilinear_map_sampler_top.sv
hdl/mbms_checker.sv
test/mbms_checker.sv
test/tb_top.sv
